>>> hw/rtl/dmx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_pkg
// shared types and constants for the surround to stereo downmix
// ----------------------------------------------------------------------------
package dmx_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 8;
    localparam int SUM_W    = 20;
    localparam int SLOT_W   = 3;   // gain table has eight slots

    // 0.707 in q15
    localparam logic signed [31:0] GAIN_707 = 32'sd23170;
    localparam int                 Q_SHIFT  = 15;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 20'sd32767;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -20'sd32768;

    typedef enum logic [1:0] {
        GAIN_NONE,
        GAIN_UNITY,
        GAIN_HALF,
        GAIN_C707
    } gain_t;

    // per-slot gain toward the left side
    function automatic gain_t left_gain(input logic [SLOT_W-1:0] slot);
        gain_t g;
        unique case (slot)
            3'd0:    g = GAIN_UNITY;
            3'd1:    g = GAIN_NONE;
            3'd2:    g = GAIN_C707;
            3'd3:    g = GAIN_HALF;
            3'd4:    g = GAIN_C707;
            3'd5:    g = GAIN_NONE;
            3'd6:    g = GAIN_C707;
            default: g = GAIN_NONE;
        endcase
        return g;
    endfunction

    // per-slot gain toward the right side
    function automatic gain_t right_gain(input logic [SLOT_W-1:0] slot);
        gain_t g;
        unique case (slot)
            3'd0:    g = GAIN_NONE;
            3'd1:    g = GAIN_UNITY;
            3'd2:    g = GAIN_C707;
            3'd3:    g = GAIN_HALF;
            3'd4:    g = GAIN_NONE;
            3'd5:    g = GAIN_C707;
            3'd6:    g = GAIN_NONE;
            default: g = GAIN_C707;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/multichannel_to_stereo_downmix_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_to_stereo_downmix_top
// folds an interleaved multichannel q15 stream into one stereo pair per frame
// ----------------------------------------------------------------------------
//  channel   handshake             payload                 direction
//  ------    -------------------   ---------------------   ---------
//  input     in_valid / in_ready   sample                  in
//  output    out_valid / out_ready left_out, right_out     out
//  config    cfg_valid / cfg_ready channel_count           in
//
//  one word per cycle sustained: input register -> mix/accumulate -> result register
//  a result is valid once the word that closes its frame has moved from the input register into the result register
//  rst_n clears position, sums, channel count (to two) and all valid flags
//  a held result stalls only a word that closes a frame, and the input behind it; other words keep flowing
//  config writes are always taken and restart framing
// ----------------------------------------------------------------------------
module multichannel_to_stereo_downmix_top #(
    parameter int MIXED_CHANNELS = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [dmx_pkg::SAMPLE_W-1:0]  sample,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [dmx_pkg::SAMPLE_W-1:0]       left_out,
    output logic signed [dmx_pkg::SAMPLE_W-1:0]       right_out,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [dmx_pkg::COUNT_W-1:0]          channel_count
);
    import dmx_pkg::*;

    // ---------------- framing state ----------------
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] pos_reg, pos_next;
    logic [COUNT_W-1:0] count_eff;
    logic               in_mono, in_last, in_mix;
    logic               in_take;

    // ---------------- input register ----------------
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [SLOT_W-1:0]          s1_slot_reg;
    logic                       s1_mix_reg;
    logic                       s1_last_reg;
    logic                       s1_mono_reg;
    logic                       s1_advance;
    logic                       out_free;

    // ---------------- accumulate ----------------
    logic signed [SUM_W-1:0]    left_sum_reg, right_sum_reg;
    logic signed [SUM_W-1:0]    left_new, right_new;
    logic signed [31:0]         prod_707;
    logic signed [SUM_W-1:0]    scaled_707;
    logic signed [SUM_W-1:0]    sample_ext;
    logic signed [SUM_W-1:0]    sample_half;

    // ---------------- result register ----------------
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] left_out_reg, right_out_reg;

    function automatic logic signed [SUM_W-1:0] pick(
        input gain_t                   g,
        input logic signed [SUM_W-1:0] full,
        input logic signed [SUM_W-1:0] half,
        input logic signed [SUM_W-1:0] c707
    );
        logic signed [SUM_W-1:0] r;
        unique case (g)
            GAIN_UNITY: r = full;
            GAIN_HALF:  r = half;
            GAIN_C707:  r = c707;
            default:    r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        priority if (v > SUM_MAX)
            r = SUM_MAX[SAMPLE_W-1:0];
        else if (v < SUM_MIN)
            r = SUM_MIN[SAMPLE_W-1:0];
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    // a zero count behaves as mono
    assign count_eff = (count_reg == '0) ? COUNT_W'(1) : count_reg;
    assign in_mono   = (count_eff == COUNT_W'(1));
    assign in_last   = ({1'b0, pos_reg} + (COUNT_W+1)'(1)) >= {1'b0, count_eff};
    assign in_mix    = ({1'b0, pos_reg} < (COUNT_W+1)'(MIXED_CHANNELS));

    // handshake: stage one moves unless it closes a frame and the result is held
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && (!(s1_last_reg || s1_mono_reg) || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_take    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        pos_next = pos_reg;
        if (cfg_valid)
            pos_next = '0;
        else if (in_take)
        begin
            if (in_mono || in_last)
                pos_next = '0;
            else
                pos_next = pos_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(2);
            pos_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
                count_reg <= channel_count;
            pos_reg <= pos_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample;
            s1_slot_reg   <= pos_reg[SLOT_W-1:0];
            s1_mix_reg    <= in_mix;
            s1_last_reg   <= in_last;
            s1_mono_reg   <= in_mono;
        end
    end

    // weighted terms; one shared 0.707 product serves both sides
    assign sample_ext  = SUM_W'(s1_sample_reg);
    assign sample_half = sample_ext >>> 1;
    assign prod_707    = 32'(s1_sample_reg) * GAIN_707;
    assign scaled_707  = SUM_W'(prod_707 >>> Q_SHIFT);

    always_comb
    begin
        left_new  = left_sum_reg;
        right_new = right_sum_reg;
        if (s1_mix_reg)
        begin
            left_new  = left_sum_reg +
                        pick(left_gain(s1_slot_reg), sample_ext, sample_half, scaled_707);
            right_new = right_sum_reg +
                        pick(right_gain(s1_slot_reg), sample_ext, sample_half, scaled_707);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_sum_reg  <= '0;
            right_sum_reg <= '0;
        end
        else if (cfg_valid)
        begin
            left_sum_reg  <= '0;
            right_sum_reg <= '0;
        end
        else if (s1_advance)
        begin
            if (s1_last_reg || s1_mono_reg)
            begin
                left_sum_reg  <= '0;
                right_sum_reg <= '0;
            end
            else
            begin
                left_sum_reg  <= left_new;
                right_sum_reg <= right_new;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && (s1_last_reg || s1_mono_reg))
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && (s1_last_reg || s1_mono_reg))
        begin
            if (s1_mono_reg)
            begin
                left_out_reg  <= s1_sample_reg;
                right_out_reg <= s1_sample_reg;
            end
            else
            begin
                left_out_reg  <= sat16(left_new);
                right_out_reg <= sat16(right_new);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    // ---------------- checks ----------------
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < count_eff)
        else $error("frame position past channel count");

    a_mono_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_mono_reg |-> s1_last_reg)
        else $error("mono word not marked as frame end");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a held result");

    a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_last_reg |=> out_valid_reg)
        else $error("frame end did not load a result");

endmodule
`default_nettype wire
